// File: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	// operation codes
	localparam logic [2:0] MD_CREATE     = 3'd0;
	localparam logic [2:0] MD_ACTIVATE   = 3'd1;
	localparam logic [2:0] MD_DEACTIVATE = 3'd2;
	localparam logic [2:0] MD_SET_PERIOD = 3'd3;
	localparam logic [2:0] MD_REMOVE     = 3'd4;
	localparam logic [2:0] MD_POLL       = 3'd5;
	localparam logic [2:0] MD_EXECUTED   = 3'd6;
	localparam logic [2:0] MD_REQUEUE    = 3'd7;

	// slot status codes as stored
	localparam logic [1:0] ST_INACTIVE = 2'd0;
	localparam logic [1:0] ST_ACTIVE   = 2'd1;
	localparam logic [1:0] ST_READY    = 2'd2;
	localparam logic [1:0] ST_CLEAN    = 2'd3;
	// reported state of a slot that holds no task
	localparam logic [2:0] ST_FREE     = 3'd4;

	// one row of the slot table
	typedef struct packed {
		logic        one_shot;
		logic [1:0]  status;
		logic [31:0] period;
		logic [31:0] last;
	} row_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic walk;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic to_scan;
		logic to_walk;
		logic hit;
		logic scan_over;
		logic walk_over;
	} sts_t;

endpackage

// File: rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer for the slot scheduler: execute, poll scan and ring walk phases.
// ----------------------------------------------------------------------------
module pts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pts_pkg::sts_t sts,
	output pts_pkg::cmd_t cmd,
	output logic          busy
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_WALK = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.to_scan) state_d = S_SCAN;
				else if (sts.to_walk) state_d = S_WALK;
				else state_d = S_IDLE;
			end
			S_SCAN: begin
				if (sts.hit) state_d = S_WALK;
				else if (sts.scan_over) state_d = S_IDLE;
			end
			S_WALK: begin
				if (sts.walk_over) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.exec   = (state_q == S_EXEC);
		cmd.scan   = (state_q == S_SCAN);
		cmd.walk   = (state_q == S_WALK);
		cmd.finish = (cmd.exec && !sts.to_scan && !sts.to_walk)
			|| (cmd.scan && !sts.hit && sts.scan_over)
			|| (cmd.walk && sts.walk_over);
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/pts_datapath.sv
// ----------------------------------------------------------------------------
// pts_datapath
// Slot table, valid bits, scan pointer and result registers of the scheduler.
// ----------------------------------------------------------------------------
module pts_datapath #(
	parameter int SLOT_COUNT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pts_pkg::cmd_t cmd,
	output pts_pkg::sts_t sts,
	input  logic [2:0]    mode,
	input  logic [3:0]    slot,
	input  logic [31:0]   now_time,
	input  logic [31:0]   period,
	input  logic          single_shot,
	output logic          done,
	output logic          accepted,
	output logic          found,
	output logic [3:0]    task_slot,
	output logic [2:0]    task_state
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	function automatic logic [SW-1:0] ring_inc(input logic [SW-1:0] p);
		ring_inc = (p == SW'(SLOT_COUNT - 1)) ? '0 : p + 1'b1;
	endfunction

	// latched command
	logic [2:0]  mode_q;
	logic [3:0]  slot_q;
	logic [31:0] now_q;
	logic [31:0] per_q;
	logic        one_q;

	// table and walk state
	pts_pkg::row_t mem [SLOT_COUNT];
	pts_pkg::row_t row_s1;
	logic [SW-1:0] pos_s1;
	logic          tag_s1;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [SW-1:0] scan_start_q;
	logic          scan_valid_q;
	logic [SW-1:0] pos_q;
	logic [SW-1:0] org_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [SW-1:0] slot_pos;
	logic          in_range;
	logic          live;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] wr_addr;
	logic          mem_we;
	pts_pkg::row_t wr_row;

	pts_pkg::row_t new_row;
	logic          wr_c;
	logic          set_v;
	logic          rm;
	logic          acc_c;
	logic [1:0]    st_after;
	logic          live_after;
	logic [2:0]    res_state;

	logic [31:0]   elapsed;
	logic          due;
	logic          hit;
	logic          scan_over;
	logic          walk_found;
	logic          walk_over;

	assign slot_pos = SW'(slot_q);
	assign in_range = 32'(slot_q) < SLOT_COUNT;
	assign live     = in_range && valid_q[slot_pos];

	// slot operation, decided on the row read for the addressed slot
	always_comb begin
		new_row    = row_s1;
		wr_c       = 1'b0;
		set_v      = 1'b0;
		rm         = 1'b0;
		acc_c      = 1'b0;
		st_after   = row_s1.status;
		live_after = live;
		case (mode_q)
			pts_pkg::MD_CREATE: begin
				if (in_range && !valid_q[slot_pos]) begin
					new_row.one_shot = one_q;
					new_row.status   = pts_pkg::ST_ACTIVE;
					new_row.period   = per_q;
					new_row.last     = now_q + per_q;
					wr_c       = 1'b1;
					set_v      = 1'b1;
					acc_c      = 1'b1;
					live_after = 1'b1;
					st_after   = pts_pkg::ST_ACTIVE;
				end
			end
			pts_pkg::MD_ACTIVATE: begin
				if (live) begin
					new_row.status = pts_pkg::ST_ACTIVE;
					wr_c     = 1'b1;
					acc_c    = 1'b1;
					st_after = pts_pkg::ST_ACTIVE;
				end
			end
			pts_pkg::MD_DEACTIVATE: begin
				if (live) begin
					new_row.status = pts_pkg::ST_INACTIVE;
					wr_c     = 1'b1;
					acc_c    = 1'b1;
					st_after = pts_pkg::ST_INACTIVE;
				end
			end
			pts_pkg::MD_SET_PERIOD: begin
				if (live) begin
					new_row.period = per_q;
					wr_c  = 1'b1;
					acc_c = 1'b1;
				end
			end
			pts_pkg::MD_REMOVE: begin
				if (live) begin
					rm    = 1'b1;
					acc_c = 1'b1;
				end
			end
			pts_pkg::MD_EXECUTED: begin
				if (live && row_s1.status == pts_pkg::ST_READY) begin
					new_row.status = pts_pkg::ST_CLEAN;
					wr_c     = 1'b1;
					acc_c    = 1'b1;
					st_after = pts_pkg::ST_CLEAN;
				end
			end
			pts_pkg::MD_REQUEUE: begin
				if (live && row_s1.status == pts_pkg::ST_CLEAN) begin
					acc_c = 1'b1;
					if (row_s1.one_shot) begin
						rm = 1'b1;
					end else begin
						new_row.status = pts_pkg::ST_ACTIVE;
						wr_c     = 1'b1;
						st_after = pts_pkg::ST_ACTIVE;
					end
				end
			end
			default: begin
				// poll: the addressed slot is only echoed
			end
		endcase
		if (rm) live_after = 1'b0;
		res_state = live_after ? {1'b0, st_after} : pts_pkg::ST_FREE;
	end

	// poll check on the registered row read from the table
	assign elapsed   = now_q - row_s1.last;
	assign due       = $signed(elapsed) >= $signed(row_s1.period);
	assign hit       = cmd.scan && tag_s1 && valid_q[pos_s1]
		&& (row_s1.status == pts_pkg::ST_ACTIVE) && due;
	assign scan_over = (cnt_q == CW'(SLOT_COUNT));

	// ring walk to the next valid slot, the origin itself excluded
	assign walk_found = (pos_q != org_q) && valid_q[pos_q];
	assign walk_over  = (pos_q == org_q) || valid_q[pos_q];

	always_comb begin
		sts.to_scan   = (mode_q == pts_pkg::MD_POLL) && scan_valid_q;
		sts.to_walk   = rm && scan_valid_q && (scan_start_q == slot_pos);
		sts.hit       = hit;
		sts.scan_over = scan_over;
		sts.walk_over = walk_over;
	end

	// table port
	assign rd_addr = cmd.load ? SW'(slot) : pos_q;
	assign mem_we  = (cmd.exec && wr_c) || hit;
	assign wr_addr = hit ? pos_s1 : slot_pos;
	always_comb begin
		wr_row = new_row;
		if (hit) begin
			wr_row        = row_s1;
			wr_row.status = pts_pkg::ST_READY;
			wr_row.last   = now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_row;
		row_s1 <= mem[rd_addr];
		pos_s1 <= rd_addr;
	end

	// command latch, pointers and results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			slot_q <= slot;
			now_q  <= now_time;
			per_q  <= period;
			one_q  <= single_shot;
			pos_q  <= SW'(slot);
		end
		if (cmd.exec) begin
			accepted   <= acc_c;
			found      <= 1'b0;
			task_slot  <= slot_q;
			task_state <= res_state;
			if (sts.to_scan) begin
				pos_q <= scan_start_q;
				cnt_q <= '0;
			end else if (sts.to_walk) begin
				pos_q <= ring_inc(slot_pos);
				org_q <= slot_pos;
			end
		end
		if (cmd.scan) begin
			if (hit) begin
				accepted   <= 1'b1;
				found      <= 1'b1;
				task_slot  <= 4'(pos_s1);
				task_state <= {1'b0, pts_pkg::ST_READY};
				pos_q      <= ring_inc(pos_s1);
				org_q      <= pos_s1;
			end else if (!scan_over) begin
				pos_q <= ring_inc(pos_q);
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.walk && !walk_over) pos_q <= ring_inc(pos_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			scan_start_q <= '0;
			scan_valid_q <= 1'b0;
			tag_s1       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			tag_s1 <= cmd.scan && !scan_over;
			if (cmd.exec) begin
				if (set_v) begin
					valid_q[slot_pos] <= 1'b1;
					if (!scan_valid_q) begin
						scan_start_q <= slot_pos;
						scan_valid_q <= 1'b1;
					end
				end
				if (rm) valid_q[slot_pos] <= 1'b0;
			end
			if (cmd.walk && walk_over) begin
				if (walk_found) scan_start_q <= pos_q;
				else if (mode_q == pts_pkg::MD_POLL) scan_start_q <= org_q;
				else scan_valid_q <= 1'b0;
			end
		end
	end

	assign done = done_q;

endmodule

// File: rtl/periodic_task_slot_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Round-robin scheduler over a table of periodic and one-shot task slots.
// ----------------------------------------------------------------------------
// channel   handshake          payload
// command   start / busy       mode, slot, now_time, period, single_shot
// result    done (strobe)      accepted, found, task_slot, task_state
//
// a command is taken when start is high and busy is low; its result is
// strobed on done for one cycle; for slot ops it follows the EXEC state
// and the done register; remove, or requeue of a one-shot, of the scan start
// adds a walk over the valid bits
// poll reads one slot per cycle through the single table port, plus a walk
// on a hit
// reset clears all slots and the scan pointer; the result side never stalls
module periodic_task_slot_scheduler #(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  slot,
	input  logic [31:0] now_time,
	input  logic [31:0] period,
	input  logic        single_shot,
	output logic        done,
	output logic        accepted,
	output logic        found,
	output logic [3:0]  task_slot,
	output logic [2:0]  task_state
);

	pts_pkg::cmd_t cmd;
	pts_pkg::sts_t sts;

	pts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	pts_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.slot        (slot),
		.now_time    (now_time),
		.period      (period),
		.single_shot (single_shot),
		.done        (done),
		.accepted    (accepted),
		.found       (found),
		.task_slot   (task_slot),
		.task_state  (task_state)
	);

endmodule

// File: rtl/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks for the periodic task slot scheduler.
// ----------------------------------------------------------------------------
module pts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        accepted,
	input logic        found,
	input logic [2:0]  task_state
);

	// a transfer always starts work
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command transfer did not raise busy");

	// a result ends the work of its command
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of a command");

	// a due task is always applied
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> accepted)
		else $error("found without accepted");

	// a picked slot is reported as ready
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> task_state == {1'b0, pts_pkg::ST_READY})
		else $error("picked slot not ready");

endmodule

bind periodic_task_slot_scheduler pts_checker u_pts_checker (.*);
